[sv/nir_pkg.sv]
// shared types, constants and codes of the nec ir frame decoder
package nir_pkg;

    // payload widths
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;

    // frame length and queue depth
    localparam int unsigned FRAME_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH    = 2;

    // register reset values
    localparam logic [TICK_W-1:0] LEADER_RST    = 16'd13500;
    localparam logic [TICK_W-1:0] REPEAT_RST    = 16'd11250;
    localparam logic [TICK_W-1:0] ZERO_RST      = 16'd1120;
    localparam logic [TICK_W-1:0] ONE_RST       = 16'd2250;
    localparam logic [TICK_W-1:0] TOLERANCE_RST = 16'd500;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER    = 3'd0,
        CFG_REPEAT    = 3'd1,
        CFG_ZERO      = 3'd2,
        CFG_ONE       = 3'd3,
        CFG_TOLERANCE = 3'd4
    } t_cfg_idx;

    // result kinds
    typedef enum logic {
        EV_FRAME  = 1'b0,
        EV_REPEAT = 1'b1
    } t_event_kind;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEAD = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // window matches of one edge interval
    typedef struct packed {
        logic leader;
        logic rpt;
        logic zero;
        logic one;
    } t_match;

    // head of the classification queue
    typedef struct packed {
        logic   valid;
        t_match match;
    } t_queue_head;

endpackage

[sv/nir_if.sv]
// request channels of the nec ir frame decoder
interface nir_edge_if;
    import nir_pkg::*;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] edge_interval;

    modport source (output valid, output edge_interval, input ready);
    modport sink   (input valid, input edge_interval, output ready);
endinterface

interface nir_event_if;
    import nir_pkg::*;
    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] command;

    modport source (output valid, output event_kind, output address, output command,
                    input ready);
    modport sink   (input valid, input event_kind, input address, input command,
                    output ready);
endinterface

[sv/nir_front.sv]
// front part: timing registers and window classification of each edge
module nir_front
    import nir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    nir_edge_if.sink              i_edge,
    input  logic                  i_queue_ready,
    output logic                  o_push,
    output t_match                o_match
);

    logic [TICK_W-1:0] r_leader;
    logic [TICK_W-1:0] r_repeat;
    logic [TICK_W-1:0] r_zero;
    logic [TICK_W-1:0] r_one;
    logic [TICK_W-1:0] r_tol;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader <= LEADER_RST;
            r_repeat <= REPEAT_RST;
            r_zero   <= ZERO_RST;
            r_one    <= ONE_RST;
            r_tol    <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEADER:    r_leader <= i_cfg_wdata[TICK_W-1:0];
                CFG_REPEAT:    r_repeat <= i_cfg_wdata[TICK_W-1:0];
                CFG_ZERO:      r_zero   <= i_cfg_wdata[TICK_W-1:0];
                CFG_ONE:       r_one    <= i_cfg_wdata[TICK_W-1:0];
                CFG_TOLERANCE: r_tol    <= i_cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // strict window test without wrap: t + tol > n and t < n + tol
    function automatic logic in_window(input logic [TICK_W-1:0] t,
                                       input logic [TICK_W-1:0] nom,
                                       input logic [TICK_W-1:0] tol);
        logic [TICK_W:0] lo_sum;
        logic [TICK_W:0] hi_sum;
        lo_sum = {1'b0, t} + {1'b0, tol};
        hi_sum = {1'b0, nom} + {1'b0, tol};
        return (lo_sum > {1'b0, nom}) && ({1'b0, t} < hi_sum);
    endfunction

    // classify against all four windows; phase priority is applied at the back
    always_comb begin
        o_match.leader = in_window(i_edge.edge_interval, r_leader, r_tol);
        o_match.rpt    = in_window(i_edge.edge_interval, r_repeat, r_tol);
        o_match.zero   = in_window(i_edge.edge_interval, r_zero, r_tol);
        o_match.one    = in_window(i_edge.edge_interval, r_one, r_tol);
    end

    assign i_edge.ready = i_queue_ready;
    assign o_push       = i_edge.valid && i_queue_ready;

endmodule

[sv/nir_queue.sv]
// short queue of classified edges between front and back
module nir_queue
    import nir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_match      i_match,
    output logic        o_ready,
    input  logic        i_pop,
    output t_queue_head o_head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_match             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_match;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_ready      = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.match = r_mem[r_rd_ptr];

endmodule

[sv/nir_back.sv]
// back part: frame state machine, bit assembly, check and result register
module nir_back
    import nir_pkg::*;
#(
    parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    nir_event_if.source o_event
);

    localparam int unsigned IDX_W = $clog2(FRAME_BITS);

    t_phase                r_phase;
    t_phase                n_phase;
    logic [IDX_W-1:0]      r_bit_idx;
    logic [IDX_W-1:0]      n_bit_idx;
    logic [FRAME_BITS-1:1] r_frame;
    logic [FRAME_BITS-1:1] n_frame;
    logic [BYTE_W-1:0]     r_last_addr;
    logic [BYTE_W-1:0]     r_last_cmd;
    logic                  r_out_valid;
    t_event_kind           r_out_kind;
    logic [BYTE_W-1:0]     r_out_addr;
    logic [BYTE_W-1:0]     r_out_cmd;

    logic                  emit;
    t_event_kind           emit_kind;
    logic [BYTE_W-1:0]     emit_addr;
    logic [BYTE_W-1:0]     emit_cmd;
    logic                  is_bit;
    logic                  bit_val;
    logic                  last_bit;
    logic [FRAME_BITS-1:0] full_frame;
    logic                  frame_ok;

    // take the next request once the result slot is free or being drained
    assign o_pop = i_head.valid && (!r_out_valid || o_event.ready);

    // bit decode, zero window has priority over one
    assign is_bit     = i_head.match.zero || i_head.match.one;
    assign bit_val    = !i_head.match.zero;
    assign last_bit   = (r_bit_idx == IDX_W'(FRAME_BITS - 1));
    assign full_frame = {bit_val, r_frame};
    assign frame_ok   =
        (full_frame[BYTE_W-1:0]          == ~full_frame[2*BYTE_W-1:BYTE_W]) &&
        (full_frame[3*BYTE_W-1:2*BYTE_W] == ~full_frame[4*BYTE_W-1:3*BYTE_W]);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_LEAD: begin
                if (i_head.match.leader) begin
                    n_phase = PH_DATA;
                end else if (i_head.match.rpt) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DATA: begin
                if (!is_bit) begin
                    n_phase = PH_LEAD;
                end else if (last_bit) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_LEAD;
        endcase
    end

    // datapath and result of the current request
    always_comb begin
        n_bit_idx = r_bit_idx;
        n_frame   = r_frame;
        emit      = 1'b0;
        emit_kind = EV_FRAME;
        emit_addr = full_frame[BYTE_W-1:0];
        emit_cmd  = full_frame[3*BYTE_W-1:2*BYTE_W];
        case (r_phase)
            PH_LEAD: begin
                if (!i_head.match.leader && i_head.match.rpt) begin
                    emit      = 1'b1;
                    emit_kind = EV_REPEAT;
                    emit_addr = r_last_addr;
                    emit_cmd  = r_last_cmd;
                end
            end
            PH_DATA: begin
                if (!is_bit) begin
                    n_bit_idx = '0;
                end else begin
                    n_frame = full_frame[FRAME_BITS-1:1];
                    if (last_bit) begin
                        n_bit_idx = '0;
                        emit      = frame_ok;
                    end else begin
                        n_bit_idx = r_bit_idx + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_idx   <= '0;
            r_frame     <= '0;
            r_last_addr <= '0;
            r_last_cmd  <= '0;
        end else if (o_pop) begin
            r_phase   <= n_phase;
            r_bit_idx <= n_bit_idx;
            r_frame   <= n_frame;
            if (emit && emit_kind == EV_FRAME) begin
                r_last_addr <= emit_addr;
                r_last_cmd  <= emit_cmd;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= emit;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_kind <= emit_kind;
            r_out_addr <= emit_addr;
            r_out_cmd  <= emit_cmd;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_out_kind;
    assign o_event.address    = r_out_addr;
    assign o_event.command    = r_out_cmd;

endmodule

[sv/nec_ir_frame_decoder.sv]
// NEC IR frame decoder: one falling-edge interval per request in, at most one
// decoded frame or repeat result out. The front compares each interval against
// the leader, repeat, zero and one windows in the cycle it is accepted and
// pushes the match flags into a two-entry queue; the back pops one entry per
// cycle while the result register is free or drained, runs the idle/lead/data
// phases, assembles the 32 bits LSB first and checks the address and command
// bytes against their inverses on the last bit. Sustained rate is one interval
// per clock while the sink is ready; the match flags pass the queue, then the
// result register. A stalled sink holds the result register; the back stops and
// the queue absorbs up to two more intervals before the input stalls.
// Write configuration registers only while idle; the block does not enforce it.
module nec_ir_frame_decoder
    import nir_pkg::*;
#(
    parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    nir_edge_if.sink              i_edge,
    nir_event_if.source           o_event
);

    logic        queue_ready;
    logic        push;
    t_match      match;
    logic        pop;
    t_queue_head head;

    // edge classification
    nir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_edge       (i_edge),
        .i_queue_ready(queue_ready),
        .o_push       (push),
        .o_match      (match)
    );

    // decoupling queue
    nir_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_match(match),
        .o_ready(queue_ready),
        .i_pop  (pop),
        .o_head (head)
    );

    // frame decode
    nir_back #(
        .FRAME_BITS(FRAME_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .o_pop  (pop),
        .o_event(o_event)
    );

    // no pop from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    // back holds while a result waits on a stalled sink
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && !o_event.ready) |-> !pop)
        else $error("pop while result stalled");

    // every new result comes from a popped request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_event.valid) |-> $past(pop))
        else $error("result without request");

endmodule

[tb/sv/nec_ir_frame_decoder_tb.sv]
// self-checking testbench of the nec ir frame decoder with random handshake timing
module nec_ir_frame_decoder_tb;
    import nir_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        t_event_kind       kind;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] cmd;
    } t_decoded;

    typedef enum {FRAME_GOOD, FRAME_BAD_CHECK, FRAME_CUT} t_frame_flavor;

    // clock, reset and register port
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // handshake drive, known from time zero
    logic              src_valid    = 1'b0;
    logic [TICK_W-1:0] src_interval = '0;
    logic              snk_ready    = 1'b0;

    // idling switches, set per traffic phase
    logic src_idle = 1'b0;
    logic snk_idle = 1'b0;

    int unsigned src_gap    = 0;
    int unsigned snk_stall  = 0;
    int unsigned quiet_run  = 0;
    int unsigned mismatches = 0;

    logic [TICK_W-1:0] pending_intervals[$];
    t_decoded          predicted_events[$];

    // timing registers as the decoder holds them
    logic [TICK_W-1:0] cfg_leader    = LEADER_RST;
    logic [TICK_W-1:0] cfg_repeat    = REPEAT_RST;
    logic [TICK_W-1:0] cfg_zero      = ZERO_RST;
    logic [TICK_W-1:0] cfg_one       = ONE_RST;
    logic [TICK_W-1:0] cfg_tolerance = TOLERANCE_RST;

    // receiver state of the prediction
    t_phase            rx_phase  = PH_IDLE;
    int unsigned       rx_count  = 0;
    logic [31:0]       rx_word   = '0;
    logic [BYTE_W-1:0] last_addr = '0;
    logic [BYTE_W-1:0] last_cmd  = '0;

    nir_edge_if  edge_ch();
    nir_event_if event_ch();

    assign edge_ch.valid         = src_valid;
    assign edge_ch.edge_interval = src_interval;
    assign event_ch.ready        = snk_ready;

    nec_ir_frame_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_edge      (edge_ch),
        .o_event     (event_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // strict window, lower bound clamps at zero instead of wrapping
    function automatic logic in_window(input logic [TICK_W-1:0] t,
                                       input logic [TICK_W-1:0] nominal);
        int unsigned tt;
        int unsigned nn;
        int unsigned tol;
        tt  = t;
        nn  = nominal;
        tol = cfg_tolerance;
        return (tt + tol > nn) && (tt < nn + tol);
    endfunction

    // advance the receiver by one edge and queue the result it causes
    function automatic void decode_edge(input logic [TICK_W-1:0] t);
        t_decoded ev;
        case (rx_phase)
            PH_LEAD: begin
                if (in_window(t, cfg_leader)) begin
                    rx_phase = PH_DATA;
                end else if (in_window(t, cfg_repeat)) begin
                    rx_phase = PH_IDLE;
                    ev.kind  = EV_REPEAT;
                    ev.addr  = last_addr;
                    ev.cmd   = last_cmd;
                    predicted_events.push_back(ev);
                end
            end
            PH_DATA: begin
                if (in_window(t, cfg_zero)) begin
                    rx_word[rx_count[4:0]] = 1'b0;
                    rx_count = rx_count + 1;
                end else if (in_window(t, cfg_one)) begin
                    rx_word[rx_count[4:0]] = 1'b1;
                    rx_count = rx_count + 1;
                end else begin
                    rx_count = 0;
                    rx_phase = PH_LEAD;
                end
                // full frame: check both bytes against their inverses
                if (rx_phase == PH_DATA && rx_count >= FRAME_BITS_DEF) begin
                    rx_count = 0;
                    rx_phase = PH_IDLE;
                    if (rx_word[7:0] == ~rx_word[15:8] && rx_word[23:16] == ~rx_word[31:24]) begin
                        last_addr = rx_word[7:0];
                        last_cmd  = rx_word[23:16];
                        ev.kind   = EV_FRAME;
                        ev.addr   = last_addr;
                        ev.cmd    = last_cmd;
                        predicted_events.push_back(ev);
                    end
                end
            end
            default: begin
                rx_phase = PH_LEAD;
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endfunction

    // interval inside a window, often right at one of its bounds
    function automatic logic [TICK_W-1:0] pick_in(input logic [TICK_W-1:0] nominal);
        int unsigned lo;
        int unsigned hi;
        int unsigned tol;
        int unsigned nn;
        tol = cfg_tolerance;
        nn  = nominal;
        if (tol == 0) begin
            return TICK_W'($urandom_range(65535, 0));
        end
        lo = (nn >= tol) ? nn - tol + 1 : 0;
        hi = nn + tol - 1;
        if (hi > 65535) begin
            hi = 65535;
        end
        case ($urandom_range(3, 0))
            0:       return TICK_W'(lo);
            1:       return TICK_W'(hi);
            default: return TICK_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // interval outside every window, where one can be found
    function automatic logic [TICK_W-1:0] pick_off();
        logic [TICK_W-1:0] t;
        t = TICK_W'($urandom_range(65535, 0));
        for (int k = 0; k < 20 && (in_window(t, cfg_leader) || in_window(t, cfg_repeat) ||
                                   in_window(t, cfg_zero) || in_window(t, cfg_one)); k++) begin
            t = TICK_W'($urandom_range(65535, 0));
        end
        return t;
    endfunction

    // start edge, leader, then the 32 bits lsb first; a cut frame stops early and ends on an off-window interval
    task automatic push_frame(input t_frame_flavor flavor);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] c;
        logic [31:0]       word;
        int unsigned       cut;
        a    = BYTE_W'($urandom_range(255, 0));
        c    = BYTE_W'($urandom_range(255, 0));
        word = {~c, c, ~a, a};
        if (flavor == FRAME_BAD_CHECK) begin
            word = word ^ (32'd1 << $urandom_range(31, 0));
        end
        cut = (flavor == FRAME_CUT) ? $urandom_range(31, 0) : 32;
        pending_intervals.push_back(TICK_W'($urandom_range(65535, 0)));
        pending_intervals.push_back(pick_in(cfg_leader));
        for (int k = 0; k < cut; k++) begin
            pending_intervals.push_back(pick_in(word[k] ? cfg_one : cfg_zero));
        end
        if (flavor == FRAME_CUT) begin
            pending_intervals.push_back(pick_off());
        end
    endtask

    task automatic push_repeat();
        pending_intervals.push_back(TICK_W'($urandom_range(65535, 0)));
        pending_intervals.push_back(pick_in(cfg_repeat));
    endtask

    // mostly well-formed frames and repeats, the rest broken or noise
    task automatic run_traffic(input int unsigned n_edges);
        int unsigned goal;
        int unsigned pick;
        goal = pending_intervals.size() + n_edges;
        while (pending_intervals.size() < goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                push_frame(FRAME_GOOD);
                repeat ($urandom_range(2, 0)) push_repeat();
            end else if (pick < 67) begin
                push_frame(FRAME_BAD_CHECK);
            end else if (pick < 78) begin
                push_frame(FRAME_CUT);
            end else if (pick < 90) begin
                push_repeat();
            end else begin
                repeat ($urandom_range(3, 1))
                    pending_intervals.push_back(TICK_W'($urandom_range(65535, 0)));
            end
        end
    endtask

    // sender holds off until every request is taken and every result is back
    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending_intervals.size() != 0 || src_valid) @(negedge i_clk);
        while (predicted_events.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_LEADER:    cfg_leader    = val;
            CFG_REPEAT:    cfg_repeat    = val;
            CFG_ZERO:      cfg_zero      = val;
            CFG_ONE:       cfg_one       = val;
            CFG_TOLERANCE: cfg_tolerance = val;
            default: ;
        endcase
    endtask

    task automatic program_timing(input logic [TICK_W-1:0] leader, input logic [TICK_W-1:0] rpt,
                                  input logic [TICK_W-1:0] zero, input logic [TICK_W-1:0] one,
                                  input logic [TICK_W-1:0] tol);
        write_reg(CFG_LEADER, leader);
        write_reg(CFG_REPEAT, rpt);
        write_reg(CFG_ZERO, zero);
        write_reg(CFG_ONE, one);
        write_reg(CFG_TOLERANCE, tol);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    // edge driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (src_valid && edge_ch.ready) begin
                decode_edge(src_interval);
                src_gap = src_idle ? $urandom_range(5, 0) : 0;
            end
            if (!src_valid || edge_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    src_valid <= 1'b0;
                end else if (pending_intervals.size() != 0) begin
                    src_valid    <= 1'b1;
                    src_interval <= pending_intervals.pop_front();
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_decoded want;
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (event_ch.valid && snk_ready) begin
                if (predicted_events.size() == 0) begin
                    note_mismatch($sformatf("unexpected result kind %0d addr %h cmd %h",
                        event_ch.event_kind, event_ch.address, event_ch.command));
                end else begin
                    want = predicted_events.pop_front();
                    if (event_ch.event_kind !== want.kind)
                        note_mismatch($sformatf("kind expected %0d actual %0d",
                            want.kind, event_ch.event_kind));
                    if (event_ch.address !== want.addr)
                        note_mismatch($sformatf("address expected %h actual %h",
                            want.addr, event_ch.address));
                    if (event_ch.command !== want.cmd)
                        note_mismatch($sformatf("command expected %h actual %h",
                            want.cmd, event_ch.command));
                end
                snk_stall = snk_idle ? $urandom_range(5, 0) : 0;
            end
            if (snk_stall > 0) begin
                snk_stall = snk_stall - 1;
                snk_ready <= 1'b0;
            end else begin
                snk_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_valid && edge_ch.ready) || (event_ch.valid && snk_ready)) begin
                quiet_run = 0;
            end else begin
                quiet_run = quiet_run + 1;
            end
            if (quiet_run >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, window bounds, aborts and an early repeat
        src_idle = 1'b1;
        snk_idle = 1'b1;
        pending_intervals.push_back(16'd0);
        pending_intervals.push_back(16'hFFFF);
        pending_intervals.push_back(REPEAT_RST);
        pending_intervals.push_back(16'd1);
        pending_intervals.push_back(LEADER_RST);
        pending_intervals.push_back(ZERO_RST);
        pending_intervals.push_back(ONE_RST);
        pending_intervals.push_back(16'd40000);
        pending_intervals.push_back(LEADER_RST - TOLERANCE_RST);
        pending_intervals.push_back(LEADER_RST + TOLERANCE_RST);
        pending_intervals.push_back(LEADER_RST - TOLERANCE_RST + 16'd1);
        pending_intervals.push_back(ZERO_RST - TOLERANCE_RST);
        pending_intervals.push_back(LEADER_RST + TOLERANCE_RST - 16'd1);
        pending_intervals.push_back(ZERO_RST - TOLERANCE_RST + 16'd1);
        pending_intervals.push_back(ZERO_RST + TOLERANCE_RST - 16'd1);
        pending_intervals.push_back(ONE_RST - TOLERANCE_RST + 16'd1);
        pending_intervals.push_back(ONE_RST + TOLERANCE_RST - 16'd1);
        pending_intervals.push_back(ONE_RST + TOLERANCE_RST);
        pending_intervals.push_back(REPEAT_RST - TOLERANCE_RST);
        pending_intervals.push_back(REPEAT_RST + TOLERANCE_RST);
        pending_intervals.push_back(REPEAT_RST + TOLERANCE_RST - 16'd1);
        wait_quiet();

        // default timing, both sides idling
        program_timing(LEADER_RST, REPEAT_RST, ZERO_RST, ONE_RST, TOLERANCE_RST);
        run_traffic(120);
        wait_quiet();

        // narrow disjoint windows, no idling
        src_idle = 1'b0;
        snk_idle = 1'b0;
        program_timing(16'd30000, 16'd20000, 16'd300, 16'd900, 16'd200);
        run_traffic(120);
        wait_quiet();

        // overlapping windows: leader wins over repeat, zero over one
        src_idle = 1'b1;
        program_timing(16'd5000, 16'd5200, 16'd1000, 16'd1100, 16'd400);
        run_traffic(120);
        wait_quiet();

        // lower bounds below zero and a leader at the top of the range
        src_idle = 1'b0;
        snk_idle = 1'b1;
        program_timing(16'hFFFF, 16'd0, 16'd100, 16'd600, 16'd300);
        run_traffic(100);
        wait_quiet();

        // empty windows: nothing can match
        src_idle = 1'b1;
        program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_traffic(30);
        wait_quiet();

        // widest windows: every nonzero interval matches
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(30);
        wait_quiet();

        // back to default timing
        program_timing(LEADER_RST, REPEAT_RST, ZERO_RST, ONE_RST, TOLERANCE_RST);
        run_traffic(100);
        wait_quiet();
        repeat (12) @(negedge i_clk);

        if (mismatches == 0 && predicted_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
